/* sv/rbst_pkg.sv */
// ----------------------------------------------------------------------------
// rbst_pkg
// Shared types and constants for the ray against box slab test pipeline.
// ----------------------------------------------------------------------------
package rbst_pkg;

	// Number format: signed two's complement Q16.16.
	localparam int COORD_W   = 32;
	localparam int FRAC_BITS = 16;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int PROD_W    = DIFF_W + COORD_W;

	// Pipeline depth: operand prep, multiply, scale, merge x/y, merge z.
	localparam int NUM_STAGES = 5;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

	localparam int AXIS_X = 0;
	localparam int AXIS_Y = 1;
	localparam int AXIS_Z = 2;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [PROD_W-1:0]  prod_t;

	typedef struct packed {
		coord_t origin_x;
		coord_t origin_y;
		coord_t origin_z;
		coord_t recip_dir_x;
		coord_t recip_dir_y;
		coord_t recip_dir_z;
	} in_item_t;

	typedef struct packed {
		logic   hit;
		coord_t dist_near;
		coord_t dist_far;
	} out_item_t;

	// One distance interval along the ray; hit clear means it is empty.
	typedef struct packed {
		logic   hit;
		coord_t tmin;
		coord_t tmax;
	} interval_t;

	// Per-stage load enables and valid flags of the pipeline.
	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
		logic [NUM_STAGES-1:0] vld;
	} stage_ctl_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// Arithmetic shift down by the fraction bits, then clamp to the coordinate range.
	function automatic coord_t scale_sat(prod_t p);
		prod_t sh;
		logic  all_zero;
		logic  all_one;
		sh       = p >>> FRAC_BITS;
		all_zero = ~|sh[PROD_W-1:COORD_W-1];
		all_one  = &sh[PROD_W-1:COORD_W-1];
		if (all_zero || all_one) begin
			return sh[COORD_W-1:0];
		end else if (sh[PROD_W-1]) begin
			return COORD_MIN;
		end else begin
			return COORD_MAX;
		end
	endfunction

endpackage

/* sv/rbst_pipe_ctrl.sv */
// ----------------------------------------------------------------------------
// rbst_pipe_ctrl
// Valid flags and stall-aware load enables for the stages of the pipeline.
// ----------------------------------------------------------------------------
module rbst_pipe_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output rbst_pkg::stage_ctl_t ctl
);

	logic [rbst_pkg::NUM_STAGES-1:0] vld_q;
	logic [rbst_pkg::NUM_STAGES-1:0] en;

	// A stage may load when it is empty or when its contents move on.
	always_comb begin
		en[rbst_pkg::NUM_STAGES-1] = !vld_q[rbst_pkg::NUM_STAGES-1] || out_ready;
		for (int k = rbst_pkg::NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	// Valid flags travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < rbst_pkg::NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[rbst_pkg::NUM_STAGES-1];
	assign ctl.en    = en;
	assign ctl.vld   = vld_q;

	// An accepted transaction always lands in the first stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted transaction did not enter the first stage");

	// An empty first stage never refuses a transaction.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[0] |-> in_ready)
		else $error("first stage empty but input not ready");

	// Without traffic at either end the number of items in flight is constant.
	a_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && in_ready) && !(out_valid && out_ready)
		|=> $countones(vld_q) == $past($countones(vld_q)))
		else $error("transaction lost or duplicated inside the pipeline");

	// A stalled result stays on the output.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("stalled result dropped");

endmodule

/* sv/rbst_axis_dist.sv */
// ----------------------------------------------------------------------------
// rbst_axis_dist
// Entry and exit distances along one axis: subtract, multiply, scale.
// ----------------------------------------------------------------------------
module rbst_axis_dist (
	input  logic                 clk,
	input  rbst_pkg::stage_ctl_t ctl,
	input  rbst_pkg::coord_t     origin,
	input  rbst_pkg::coord_t     recip,
	input  rbst_pkg::coord_t     box_min,
	input  rbst_pkg::coord_t     box_max,
	output rbst_pkg::coord_t     dist_lo,
	output rbst_pkg::coord_t     dist_hi
);

	logic             pos;
	rbst_pkg::coord_t near_bound;
	rbst_pkg::coord_t far_bound;

	rbst_pkg::diff_t  diff_near_s1;
	rbst_pkg::diff_t  diff_far_s1;
	rbst_pkg::coord_t recip_s1;
	rbst_pkg::prod_t  prod_near_s2;
	rbst_pkg::prod_t  prod_far_s2;
	rbst_pkg::coord_t lo_s3;
	rbst_pkg::coord_t hi_s3;

	// Bounds trade places when the reciprocal is zero or negative.
	always_comb begin
		pos        = (recip > rbst_pkg::coord_t'(0));
		near_bound = pos ? box_min : box_max;
		far_bound  = pos ? box_max : box_min;
	end

	// Stage 1: exact differences, one bit wider than the coordinates.
	always_ff @(posedge clk) begin
		if (ctl.en[0]) begin
			diff_near_s1 <= rbst_pkg::diff_t'(near_bound) - rbst_pkg::diff_t'(origin);
			diff_far_s1  <= rbst_pkg::diff_t'(far_bound) - rbst_pkg::diff_t'(origin);
			recip_s1     <= recip;
		end
	end

	// Stage 2: exact signed products.
	always_ff @(posedge clk) begin
		if (ctl.en[1]) begin
			prod_near_s2 <= rbst_pkg::prod_t'(diff_near_s1) * rbst_pkg::prod_t'(recip_s1);
			prod_far_s2  <= rbst_pkg::prod_t'(diff_far_s1) * rbst_pkg::prod_t'(recip_s1);
		end
	end

	// Stage 3: drop the fraction bits and saturate.
	always_ff @(posedge clk) begin
		if (ctl.en[2]) begin
			lo_s3 <= rbst_pkg::scale_sat(prod_near_s2);
			hi_s3 <= rbst_pkg::scale_sat(prod_far_s2);
		end
	end

	assign dist_lo = lo_s3;
	assign dist_hi = hi_s3;

endmodule

/* sv/rbst_interval_merge.sv */
// ----------------------------------------------------------------------------
// rbst_interval_merge
// Registered intersection of a running interval with one axis interval.
// ----------------------------------------------------------------------------
module rbst_interval_merge (
	input  logic                clk,
	input  logic                en,
	input  rbst_pkg::interval_t acc,
	input  rbst_pkg::coord_t    axis_lo,
	input  rbst_pkg::coord_t    axis_hi,
	output rbst_pkg::interval_t merged
);

	rbst_pkg::interval_t next_iv;
	rbst_pkg::interval_t iv_reg_q;
	logic                gap;

	// Touching intervals still overlap; only a strict gap is a miss.
	// A miss reports zero distances.
	always_comb begin
		gap          = (axis_hi < acc.tmin) || (acc.tmax < axis_lo);
		next_iv.hit  = acc.hit && !gap;
		next_iv.tmin = (acc.tmin < axis_lo) ? axis_lo : acc.tmin;
		next_iv.tmax = (axis_hi < acc.tmax) ? axis_hi : acc.tmax;
		if (!next_iv.hit) begin
			next_iv.tmin = '0;
			next_iv.tmax = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			iv_reg_q <= next_iv;
		end
	end

	assign merged = iv_reg_q;

endmodule

/* sv/ray_box_slab_test_unit.sv */
// ----------------------------------------------------------------------------
// ray_box_slab_test_unit
// Slab test of one ray per transaction against a box held in registers.
// ----------------------------------------------------------------------------
// Usage:
//   The box corners sit in six registers written through cfg_we, cfg_index and
//   cfg_wdata (0..2 lower corner x/y/z, 3..5 upper corner x/y/z; other indexes
//   are ignored). Write them only while no ray is in flight.
//   Each input transaction carries the ray origin and the per-axis reciprocal
//   direction in Q16.16. Each yields one result: hit, and the entry and exit
//   distances, both zero on a miss.
//   Each accepted ray passes through five register stages (operand prep,
//   multiply, scale and saturate, x/y merge, z merge). Throughput: one ray
//   per cycle while out_ready is not held low; the six parallel 33x32
//   multipliers of the second stage set the clock period.
//   When out_ready is low the pipeline holds; items close up into empty
//   stages, and in_ready falls only once every stage is full.
//   Reset clears all valid flags and the box registers to zero.
// ----------------------------------------------------------------------------
module ray_box_slab_test_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  rbst_pkg::in_item_t                  in_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output rbst_pkg::out_item_t                 out_item,
	input  logic                                cfg_we,
	input  logic [rbst_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rbst_pkg::COORD_W-1:0]        cfg_wdata
);

	rbst_pkg::coord_t     box_min_q [3];
	rbst_pkg::coord_t     box_max_q [3];
	rbst_pkg::stage_ctl_t ctl;
	rbst_pkg::coord_t     lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
	rbst_pkg::coord_t     z_lo_s4;
	rbst_pkg::coord_t     z_hi_s4;
	rbst_pkg::interval_t  iv_x;
	rbst_pkg::interval_t  iv_s4;
	rbst_pkg::interval_t  iv_s5;

	// Box corner registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				box_min_q[i] <= '0;
				box_max_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				rbst_pkg::REG_BOX_MIN_X: box_min_q[rbst_pkg::AXIS_X] <= cfg_wdata;
				rbst_pkg::REG_BOX_MIN_Y: box_min_q[rbst_pkg::AXIS_Y] <= cfg_wdata;
				rbst_pkg::REG_BOX_MIN_Z: box_min_q[rbst_pkg::AXIS_Z] <= cfg_wdata;
				rbst_pkg::REG_BOX_MAX_X: box_max_q[rbst_pkg::AXIS_X] <= cfg_wdata;
				rbst_pkg::REG_BOX_MAX_Y: box_max_q[rbst_pkg::AXIS_Y] <= cfg_wdata;
				rbst_pkg::REG_BOX_MAX_Z: box_max_q[rbst_pkg::AXIS_Z] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Handshake and stage enables.
	rbst_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl)
	);

	// Per-axis distances, stages 1 to 3.
	rbst_axis_dist u_axis_x (
		.clk     (clk),
		.ctl     (ctl),
		.origin  (in_item.origin_x),
		.recip   (in_item.recip_dir_x),
		.box_min (box_min_q[rbst_pkg::AXIS_X]),
		.box_max (box_max_q[rbst_pkg::AXIS_X]),
		.dist_lo (lo_x),
		.dist_hi (hi_x)
	);

	rbst_axis_dist u_axis_y (
		.clk     (clk),
		.ctl     (ctl),
		.origin  (in_item.origin_y),
		.recip   (in_item.recip_dir_y),
		.box_min (box_min_q[rbst_pkg::AXIS_Y]),
		.box_max (box_max_q[rbst_pkg::AXIS_Y]),
		.dist_lo (lo_y),
		.dist_hi (hi_y)
	);

	rbst_axis_dist u_axis_z (
		.clk     (clk),
		.ctl     (ctl),
		.origin  (in_item.origin_z),
		.recip   (in_item.recip_dir_z),
		.box_min (box_min_q[rbst_pkg::AXIS_Z]),
		.box_max (box_max_q[rbst_pkg::AXIS_Z]),
		.dist_lo (lo_z),
		.dist_hi (hi_z)
	);

	// Stage 4: intersect x with y; hold the z interval alongside.
	assign iv_x = '{hit: 1'b1, tmin: lo_x, tmax: hi_x};

	rbst_interval_merge u_merge_xy (
		.clk     (clk),
		.en      (ctl.en[3]),
		.acc     (iv_x),
		.axis_lo (lo_y),
		.axis_hi (hi_y),
		.merged  (iv_s4)
	);

	always_ff @(posedge clk) begin
		if (ctl.en[3]) begin
			z_lo_s4 <= lo_z;
			z_hi_s4 <= hi_z;
		end
	end

	// Stage 5: intersect with z; this register drives the output.
	rbst_interval_merge u_merge_z (
		.clk     (clk),
		.en      (ctl.en[4]),
		.acc     (iv_s4),
		.axis_lo (z_lo_s4),
		.axis_hi (z_hi_s4),
		.merged  (iv_s5)
	);

	assign out_item.hit       = iv_s5.hit;
	assign out_item.dist_near = iv_s5.tmin;
	assign out_item.dist_far  = iv_s5.tmax;

endmodule
